[hdl/gbwf_pkg.sv]
// Shared constants for the Gaussian blur window filter.
package gbwf_pkg;

    localparam int MAX_WIDTH_DEF      = 1024;
    localparam int MAX_RADIUS_DEF     = 3;
    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int MAX_HEIGHT         = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int PIX_W      = 24;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_W0     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_W1     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_W2     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_W3     = 3'd6;

    localparam logic [1:0]  RST_RADIUS = 2'd1;
    localparam logic [10:0] RST_WIDTH  = 11'd640;
    localparam logic [12:0] RST_HEIGHT = 13'd480;
    localparam logic [16:0] RST_W0     = 17'd29614;
    localparam logic [16:0] RST_W1     = 17'd17961;
    localparam logic [16:0] RST_W2     = 17'd0;
    localparam logic [16:0] RST_W3     = 17'd0;

endpackage

[hdl/gbwf_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module gbwf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/gaussian_blur_window_filter.sv]
// Top level of the Gaussian blur window filter with its line store and MAC sequencer.
// A transaction that yields no pixel leaves the block ready for the next one. An edge
// pixel takes a single read of the line store; an interior pixel reads its whole
// (2*radius+1)^2 window through the single read port, one window tap per cycle.
// The next input transaction is taken once the current result sits in the output register.
// Reset (synchronous, active low) restores the register defaults and clears all counters;
// the line store is not cleared, as every read hits a pixel written earlier in the frame.
module gaussian_blur_window_filter #(
    parameter int MAX_WIDTH      = gbwf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS     = gbwf_pkg::MAX_RADIUS_DEF,
    parameter int COEF_FRAC_BITS = gbwf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [gbwf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gbwf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Input stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [23:0]                      s_axis_tdata,  // red_in, green_in, blue_in
    input  logic                             s_axis_tuser,  // op
    // Output stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [23:0]                      m_axis_tdata,  // red_out, green_out, blue_out
    output logic                             m_axis_tlast   // frame_end
);

    // Derived sizes.
    localparam int STORE_ROWS = 2 * MAX_RADIUS + 1;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int SW   = $clog2(STORE_ROWS);
    localparam int KW   = $clog2(STORE_ROWS);
    localparam int HW   = 13;
    localparam int YW   = 12;
    localparam int NW   = $clog2(MAX_WIDTH * gbwf_pkg::MAX_HEIGHT + 1);
    localparam int AW   = SW + CW;
    localparam int DEPTH = STORE_ROWS * (1 << CW);
    localparam int CF   = COEF_FRAC_BITS + 1;
    localparam int EW   = (CF > 17) ? CF : 17;
    localparam int PW   = 2 * CF;
    localparam int MW   = PW + 8;
    localparam int ACCW = MW + 6;

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    // Configuration registers.
    logic [1:0]  r_radius;
    logic [10:0] r_fwidth;
    logic [12:0] r_fheight;
    logic [16:0] r_wgt [4];

    // Effective geometry after clamping.
    logic [1:0]    eff_r;
    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic [NW-1:0] lag;

    always_comb begin
        eff_r = (int'(r_radius) > MAX_RADIUS) ? 2'(MAX_RADIUS) : r_radius;
        if (r_fwidth == 11'd0) begin
            eff_w = WW'(1);
        end else if (int'(r_fwidth) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_fwidth);
        end
        if (r_fheight == 13'd0) begin
            eff_h = HW'(1);
        end else if (int'(r_fheight) > gbwf_pkg::MAX_HEIGHT) begin
            eff_h = HW'(gbwf_pkg::MAX_HEIGHT);
        end else begin
            eff_h = r_fheight;
        end
        lag = NW'(eff_r) * NW'(eff_w) + NW'(eff_r);
    end

    // Frame position counters.
    logic [CW-1:0] r_in_col;
    logic [YW-1:0] r_in_row;
    logic [SW-1:0] r_in_slot;
    logic [NW-1:0] r_in_cnt;
    logic          r_loaded;
    logic [CW-1:0] r_ox;
    logic [YW-1:0] r_oy;
    logic [SW-1:0] r_oslot;

    // Sequencer and window walk.
    logic [1:0]    r_state;
    logic          r_edge;
    logic [KW-1:0] r_i;
    logic [KW-1:0] r_j;
    logic [SW-1:0] r_rs;

    // MAC pipeline.
    logic            r_va;
    logic            r_vb;
    logic [PW-1:0]   r_wa;
    logic [MW-1:0]   r_p [3];
    logic [ACCW-1:0] r_acc [3];
    logic [23:0]     r_pass;

    // Output register.
    logic        r_out_valid;
    logic [23:0] r_out_data;
    logic        r_out_last;

    // Memory ports.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [23:0]   ram_rdata;

    gbwf_ram #(
        .WIDTH (gbwf_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (s_axis_tdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    logic accept;
    logic is_drain;
    logic do_write;
    logic launch;
    logic out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_drain      = s_axis_tuser;
    assign do_write      = accept && !is_drain && !r_loaded;
    // A pixel emits once the lag is covered; a drain emits only after the frame is in.
    assign launch        = (do_write && (r_in_cnt >= lag)) || (accept && is_drain && r_loaded);
    assign out_free      = !r_out_valid || m_axis_tready;

    assign ram_we    = do_write;
    assign ram_waddr = {r_in_slot, r_in_col};

    // Clamped one-dimensional coefficient for an offset.
    function automatic logic [CF-1:0] coef(input logic [KW-1:0] k, input logic [16:0] w0,
                                           input logic [16:0] w1, input logic [16:0] w2,
                                           input logic [16:0] w3);
        logic [EW-1:0] w;
        logic [EW-1:0] lim;
        begin
            lim = EW'(1) << COEF_FRAC_BITS;
            case (k)
                KW'(0):  w = EW'(w0);
                KW'(1):  w = EW'(w1);
                KW'(2):  w = EW'(w2);
                KW'(3):  w = EW'(w3);
                default: w = '0;
            endcase
            if (w > lim) begin
                w = lim;
            end
            coef = CF'(w);
        end
    endfunction

    // Offsets of the current tap from the window centre.
    logic [KW-1:0] ki;
    logic [KW-1:0] kj;
    logic [CW:0]   rd_col;
    logic          edge_now;

    always_comb begin
        ki = (r_i > KW'(eff_r)) ? (r_i - KW'(eff_r)) : (KW'(eff_r) - r_i);
        kj = (r_j > KW'(eff_r)) ? (r_j - KW'(eff_r)) : (KW'(eff_r) - r_j);
        rd_col = {1'b0, r_ox} + (CW+1)'(r_j) - (CW+1)'(eff_r);
        if (r_edge) begin
            ram_raddr = {r_oslot, r_ox};
        end else begin
            ram_raddr = {r_rs, rd_col[CW-1:0]};
        end
        edge_now = (r_oy < YW'(eff_r)) || (WW'(r_ox) < WW'(eff_r)) ||
                   ((HW'(r_oy) + HW'(eff_r)) >= eff_h) ||
                   ((WW'(r_ox) + WW'(eff_r)) >= eff_w);
    end

    // Saturated blurred pixel; red sits in the low byte.
    logic [23:0] blur_pix;
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (|r_acc[c][ACCW-1:2*COEF_FRAC_BITS+8]) begin
                blur_pix[8*c +: 8] = 8'hFF;
            end else begin
                blur_pix[8*c +: 8] = r_acc[c][2*COEF_FRAC_BITS +: 8];
            end
        end
    end

    logic last_col;
    logic last_row;
    assign last_col = (WW'(r_ox) + WW'(1)) >= eff_w;
    assign last_row = (HW'(r_oy) + HW'(1)) >= eff_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= gbwf_pkg::RST_RADIUS;
            r_fwidth    <= gbwf_pkg::RST_WIDTH;
            r_fheight   <= gbwf_pkg::RST_HEIGHT;
            r_wgt[0]    <= gbwf_pkg::RST_W0;
            r_wgt[1]    <= gbwf_pkg::RST_W1;
            r_wgt[2]    <= gbwf_pkg::RST_W2;
            r_wgt[3]    <= gbwf_pkg::RST_W3;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_in_slot   <= '0;
            r_in_cnt    <= '0;
            r_loaded    <= 1'b0;
            r_ox        <= '0;
            r_oy        <= '0;
            r_oslot     <= '0;
            r_state     <= S_IDLE;
            r_va        <= 1'b0;
            r_vb        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            // Pipeline stage after the read: one product per channel.
            r_va <= 1'b0;
            r_vb <= r_va;
            if (r_va) begin
                for (int c = 0; c < 3; c++) begin
                    r_p[c] <= MW'(ram_rdata[8*c +: 8]) * MW'(r_wa);
                end
                r_pass <= ram_rdata;
            end
            if (r_vb) begin
                for (int c = 0; c < 3; c++) begin
                    r_acc[c] <= r_acc[c] + ACCW'(r_p[c]);
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (do_write) begin
                        r_in_cnt <= r_in_cnt + NW'(1);
                        if ((WW'(r_in_col) + WW'(1)) >= eff_w) begin
                            r_in_col  <= '0;
                            r_in_slot <= (int'(r_in_slot) == STORE_ROWS - 1) ? '0
                                         : r_in_slot + SW'(1);
                            if ((HW'(r_in_row) + HW'(1)) >= eff_h) begin
                                r_in_row  <= '0;
                                r_in_slot <= '0;
                                r_in_cnt  <= '0;
                                r_loaded  <= 1'b1;
                            end else begin
                                r_in_row <= r_in_row + YW'(1);
                            end
                        end else begin
                            r_in_col <= r_in_col + CW'(1);
                        end
                    end
                    if (launch) begin
                        r_state <= S_ISSUE;
                        r_edge  <= edge_now;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_rs    <= (r_oslot >= SW'(eff_r)) ? (r_oslot - SW'(eff_r))
                                   : SW'(int'(r_oslot) + STORE_ROWS - int'(eff_r));
                        for (int c = 0; c < 3; c++) begin
                            r_acc[c] <= '0;
                        end
                    end
                end
                S_ISSUE: begin
                    r_va <= 1'b1;
                    r_wa <= PW'(coef(ki, r_wgt[0], r_wgt[1], r_wgt[2], r_wgt[3])) *
                            PW'(coef(kj, r_wgt[0], r_wgt[1], r_wgt[2], r_wgt[3]));
                    if (r_edge) begin
                        r_state <= S_WAIT;
                    end else if (r_j == KW'(2 * eff_r)) begin
                        r_j  <= '0;
                        r_rs <= (int'(r_rs) == STORE_ROWS - 1) ? '0 : r_rs + SW'(1);
                        if (r_i == KW'(2 * eff_r)) begin
                            r_state <= S_WAIT;
                        end else begin
                            r_i <= r_i + KW'(1);
                        end
                    end else begin
                        r_j <= r_j + KW'(1);
                    end
                end
                S_WAIT: begin
                    if (!r_va && !r_vb) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_edge ? r_pass : blur_pix;
                        r_out_last  <= 1'b0;
                        r_state     <= S_IDLE;
                        if (last_col) begin
                            r_ox    <= '0;
                            r_oslot <= (int'(r_oslot) == STORE_ROWS - 1) ? '0
                                       : r_oslot + SW'(1);
                            r_oy    <= r_oy + YW'(1);
                            if (last_row) begin
                                // Final pixel of the frame: start the next frame.
                                r_out_last <= 1'b1;
                                r_oy       <= '0;
                                r_oslot    <= '0;
                                r_in_col   <= '0;
                                r_in_row   <= '0;
                                r_in_slot  <= '0;
                                r_in_cnt   <= '0;
                                r_loaded   <= 1'b0;
                            end
                        end else begin
                            r_ox <= r_ox + CW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // The user must write registers only while idle; the block itself does not enforce it.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    gbwf_pkg::REG_RADIUS,
                    gbwf_pkg::REG_WIDTH,
                    gbwf_pkg::REG_HEIGHT: begin
                        if (i_cfg_idx == gbwf_pkg::REG_RADIUS) begin
                            r_radius <= i_cfg_data[1:0];
                        end
                        if (i_cfg_idx == gbwf_pkg::REG_WIDTH) begin
                            r_fwidth <= i_cfg_data[10:0];
                        end
                        if (i_cfg_idx == gbwf_pkg::REG_HEIGHT) begin
                            r_fheight <= i_cfg_data[12:0];
                        end
                        r_in_col  <= '0;
                        r_in_row  <= '0;
                        r_in_slot <= '0;
                        r_in_cnt  <= '0;
                        r_loaded  <= 1'b0;
                        r_ox      <= '0;
                        r_oy      <= '0;
                        r_oslot   <= '0;
                    end
                    gbwf_pkg::REG_W0: r_wgt[0] <= i_cfg_data;
                    gbwf_pkg::REG_W1: r_wgt[1] <= i_cfg_data;
                    gbwf_pkg::REG_W2: r_wgt[2] <= i_cfg_data;
                    gbwf_pkg::REG_W3: r_wgt[3] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // A new result is only loaded from the output state.
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT)
        else $error("output loaded outside the output state");

    // The MAC pipeline is empty whenever a new transaction can be accepted.
    a_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_va && !r_vb))
        else $error("MAC pipeline busy while idle");

    // Line store writes only happen on accepted pixels.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE) && !r_loaded)
        else $error("line store written outside an accepted pixel");

    // The output column never reaches the frame width.
    a_ox_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (WW'(r_ox) < eff_w))
        else $error("output column out of range");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the Gaussian blur window filter: directed and random frames.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // The run is stopped by force if it reaches this many cycles.
    localparam int CYCLE_LIMIT = 1_000_000;
    // The slowest transaction walks a 7x7 window; this covers any transaction still
    // being worked on.
    localparam int SETTLE      = 80;
    localparam int STORE_ROWS  = 2 * gbwf_pkg::MAX_RADIUS_DEF + 1;
    // A frame abandoned part way sends at most this many pixels.
    localparam int CUT_MAX     = 120;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [gbwf_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [gbwf_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [23:0]                     s_axis_tdata;   // red_in, green_in, blue_in
    logic                            s_axis_tuser;   // op
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [23:0]                     m_axis_tdata;   // red_out, green_out, blue_out
    logic                            m_axis_tlast;   // frame_end

    gaussian_blur_window_filter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // A blurred pixel as it leaves the block: frame_end above the 24 bits of tdata.
    typedef struct packed {
        logic        last;
        logic [23:0] pix;
    } t_blur_pix;

    // What the stimulus knows about a transaction before it is offered. Where the
    // result can be read off by eye it is typed in and used instead of the predictor.
    typedef struct {
        logic        op;
        logic [23:0] pix;
        bit          typed;
        t_blur_pix   known;
    } t_pixel_note;

    // Copy of the filter's registers and state, kept by the predictor.
    logic [1:0]  cfg_radius;
    logic [10:0] cfg_width;
    logic [12:0] cfg_height;
    logic [16:0] cfg_weight [4];
    logic [23:0] line_rows [STORE_ROWS][gbwf_pkg::MAX_WIDTH_DEF];
    int unsigned row_pos, col_pos, out_pos;
    bit          frame_loaded;

    t_blur_pix   pending_pix[$];
    t_pixel_note offered_notes[$];
    int          error_count;
    int          cycle_count;
    bit          calm;

    function automatic int unsigned eff_width();
        if (cfg_width == 0) return 1;
        return (cfg_width > gbwf_pkg::MAX_WIDTH_DEF) ? gbwf_pkg::MAX_WIDTH_DEF : cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        if (cfg_height == 0) return 1;
        return (cfg_height > gbwf_pkg::MAX_HEIGHT) ? gbwf_pkg::MAX_HEIGHT : cfg_height;
    endfunction

    function automatic longint unsigned tap_weight(int unsigned k);
        longint unsigned lim;
        lim = longint'(1) << gbwf_pkg::COEF_FRAC_BITS_DEF;
        return (cfg_weight[k] > lim) ? lim : longint'(cfg_weight[k]);
    endfunction

    function automatic void restart_frame();
        row_pos = 0;
        col_pos = 0;
        out_pos = 0;
        frame_loaded = 0;
    endfunction

    // Produces the next output pixel of the frame and moves the output position on.
    function automatic t_blur_pix blur_next();
        int unsigned w, h, r, oy, ox;
        longint unsigned acc [3];
        longint unsigned wgt, v;
        logic [23:0] p;
        t_blur_pix res;
        w = eff_width();
        h = eff_height();
        r = cfg_radius;
        oy = out_pos / w;
        ox = out_pos % w;
        res.pix = line_rows[oy % STORE_ROWS][ox % gbwf_pkg::MAX_WIDTH_DEF];
        if (!(oy < r || ox < r || oy + r >= h || ox + r >= w)) begin
            acc = '{0, 0, 0};
            for (int i = 0; i <= 2 * r; i++) begin
                for (int j = 0; j <= 2 * r; j++) begin
                    wgt = tap_weight((i > r) ? i - r : r - i) *
                          tap_weight((j > r) ? j - r : r - j);
                    p = line_rows[(oy + i - r) % STORE_ROWS]
                                 [(ox + j - r) % gbwf_pkg::MAX_WIDTH_DEF];
                    for (int c = 0; c < 3; c++)
                        acc[c] += longint'(p[8*c +: 8]) * wgt;
                end
            end
            for (int c = 0; c < 3; c++) begin
                v = acc[c] >> (2 * gbwf_pkg::COEF_FRAC_BITS_DEF);
                res.pix[8*c +: 8] = (v > 255) ? 8'hFF : v[7:0];
            end
        end
        out_pos++;
        res.last = (out_pos >= w * h);
        if (res.last)
            restart_frame();
        return res;
    endfunction

    // Advances the predicted filter by one accepted transaction.
    function automatic bit predict_blur(input logic op, input logic [23:0] pix,
                                        output t_blur_pix res);
        int unsigned w, lag, n;
        w = eff_width();
        lag = cfg_radius * w + cfg_radius;
        res = '0;
        if (op == OP_DRAIN) begin
            if (!frame_loaded) return 0;
            res = blur_next();
            return 1;
        end
        if (frame_loaded) return 0;
        n = row_pos * w + col_pos;
        line_rows[row_pos % STORE_ROWS][col_pos % gbwf_pkg::MAX_WIDTH_DEF] = pix;
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= eff_height()) begin
                row_pos = 0;
                frame_loaded = 1;
            end
        end
        if (n >= lag) begin
            res = blur_next();
            return 1;
        end
        return 0;
    endfunction

    // Both handshakes are sampled here, at the edge where they complete. Results are
    // checked before the new input is predicted; a result can never belong to an
    // input accepted at the same edge.
    always @(posedge i_clk) begin : monitor
        t_pixel_note note;
        t_blur_pix   res;
        t_blur_pix   want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_pix.size() == 0) begin
                    $display("%0t: unexpected pixel, expected none, got last=%0b data=%06h",
                             $realtime, m_axis_tlast, m_axis_tdata);
                    error_count++;
                end else begin
                    want = pending_pix.pop_front();
                    if (m_axis_tdata !== want.pix || m_axis_tlast !== want.last) begin
                        $display("%0t: mismatch, expected last=%0b data=%06h, got last=%0b data=%06h",
                                 $realtime, want.last, want.pix, m_axis_tlast, m_axis_tdata);
                        error_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                note = offered_notes.pop_front();
                if (predict_blur(s_axis_tuser, s_axis_tdata, res))
                    pending_pix.push_back(note.typed ? note.known : res);
            end
        end
    end

    // The receiver stalls about one cycle in ten, never while the calm stretch runs.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 10);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offers one transaction, with a random gap before it, and returns at the edge
    // that accepts it. tready is looked at on the falling edge, where it is stable.
    task automatic send_transaction(input logic op, input logic [23:0] pix,
                                    input bit typed = 0, input t_blur_pix known = '0);
        t_pixel_note note;
        note.op = op;
        note.pix = pix;
        note.typed = typed;
        note.known = known;
        while (!calm && $urandom_range(99) < 10) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        offered_notes.push_back(note);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= op;
        @(negedge i_clk);
        while (!s_axis_tready)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Waits until every expected pixel has come and the block has gone quiet.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_pix.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [gbwf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gbwf_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            gbwf_pkg::REG_RADIUS: begin cfg_radius = val[1:0];  restart_frame(); end
            gbwf_pkg::REG_WIDTH:  begin cfg_width  = val[10:0]; restart_frame(); end
            gbwf_pkg::REG_HEIGHT: begin cfg_height = val[12:0]; restart_frame(); end
            gbwf_pkg::REG_W0:     cfg_weight[0] = val;
            gbwf_pkg::REG_W1:     cfg_weight[1] = val;
            gbwf_pkg::REG_W2:     cfg_weight[2] = val;
            gbwf_pkg::REG_W3:     cfg_weight[3] = val;
            default: ;
        endcase
    endtask

    function automatic logic [16:0] random_weight();
        case ($urandom_range(7))
            0:       return 17'd0;
            1:       return 17'd65536;
            2:       return 17'h1FFFF;   // above one, so it saturates
            default: return 17'($urandom_range(40000));
        endcase
    endfunction

    function automatic logic [23:0] random_pixel();
        logic [23:0] p;
        p = 24'($urandom);
        for (int c = 0; c < 3; c++)
            case ($urandom_range(9))
                0: p[8*c +: 8] = 8'h00;
                1: p[8*c +: 8] = 8'hFF;
                default: ;
            endcase
        return p;
    endfunction

    // Programs a geometry and weight set, then streams one frame through it.
    // A frame cut short is left for the next geometry write to clear.
    task automatic run_frame(input logic [1:0] r, input logic [10:0] w, input logic [12:0] h,
                             input logic [16:0] wc, input logic [16:0] w1,
                             input logic [16:0] w2, input logic [16:0] w3, input bit cut_short);
        int unsigned total, lag, pixels;
        write_reg(gbwf_pkg::REG_RADIUS, 17'(r));
        write_reg(gbwf_pkg::REG_WIDTH, 17'(w));
        write_reg(gbwf_pkg::REG_HEIGHT, 17'(h));
        write_reg(gbwf_pkg::REG_W0, wc);
        write_reg(gbwf_pkg::REG_W1, w1);
        write_reg(gbwf_pkg::REG_W2, w2);
        write_reg(gbwf_pkg::REG_W3, w3);
        total = eff_width() * eff_height();
        lag = r * eff_width() + r;
        pixels = cut_short ? $urandom_range((total - 1 < CUT_MAX) ? total - 1 : CUT_MAX)
                           : total;
        for (int k = 0; k < pixels; k++) begin
            if ($urandom_range(99) < 4)
                send_transaction(OP_DRAIN, 24'($urandom));   // drain before the frame is in
            send_transaction(OP_PIXEL, random_pixel());
        end
        if (!cut_short) begin
            if (lag > 0 && total > 0 && $urandom_range(3) == 0)
                send_transaction(OP_PIXEL, 24'($urandom));   // ignored, outputs still pending
            for (int k = 0; k < ((lag < total) ? lag : total); k++)
                send_transaction(OP_DRAIN, 24'($urandom));
            if ($urandom_range(3) == 0)
                send_transaction(OP_DRAIN, 24'($urandom));   // nothing left to drain
        end
        wait_idle();
    endtask

    t_pixel_note directed_rows [$];

    // Appends a row of the directed table: a pixel or drain and, where given, its result.
    function automatic void add_row(input logic op, input logic [23:0] pix,
                                    input bit typed = 0, input logic last = 0,
                                    input logic [23:0] out_pix = '0);
        t_pixel_note row;
        row.op = op;
        row.pix = pix;
        row.typed = typed;
        row.known.last = last;
        row.known.pix = out_pix;
        directed_rows.push_back(row);
    endfunction

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        calm          = 0;
        cfg_radius    = gbwf_pkg::RST_RADIUS;
        cfg_width     = gbwf_pkg::RST_WIDTH;
        cfg_height    = gbwf_pkg::RST_HEIGHT;
        cfg_weight    = '{gbwf_pkg::RST_W0, gbwf_pkg::RST_W1, gbwf_pkg::RST_W2,
                          gbwf_pkg::RST_W3};
        restart_frame();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: a 3x3 frame at radius one with the default weights. The
        // first output follows the fifth pixel; only the centre pixel is blurred,
        // and the edge pixels come back unchanged.
        write_reg(gbwf_pkg::REG_WIDTH, 17'd3);
        write_reg(gbwf_pkg::REG_HEIGHT, 17'd3);
        add_row(OP_DRAIN, 24'hFFFFFF);                        // frame not yet in
        add_row(OP_PIXEL, 24'h000000);
        add_row(OP_PIXEL, 24'hFFFFFF);
        add_row(OP_PIXEL, 24'h0000FF);
        add_row(OP_PIXEL, 24'h00FF00);
        add_row(OP_PIXEL, 24'hFF0000, 1, 0, 24'h000000);
        add_row(OP_PIXEL, 24'h123456, 1, 0, 24'hFFFFFF);
        add_row(OP_PIXEL, 24'hFFFFFF, 1, 0, 24'h0000FF);
        add_row(OP_PIXEL, 24'h80807F, 1, 0, 24'h00FF00);
        add_row(OP_PIXEL, 24'h010101);                        // the blurred centre
        add_row(OP_PIXEL, 24'hABCDEF);                        // ignored, frame is full
        add_row(OP_DRAIN, 24'h000000, 1, 0, 24'h123456);
        add_row(OP_DRAIN, 24'h000000, 1, 0, 24'hFFFFFF);
        add_row(OP_DRAIN, 24'h000000, 1, 0, 24'h80807F);
        add_row(OP_DRAIN, 24'h000000, 1, 1, 24'h010101);
        add_row(OP_DRAIN, 24'h000000);                        // nothing pending
        foreach (directed_rows[k])
            send_transaction(directed_rows[k].op, directed_rows[k].pix,
                             directed_rows[k].typed, directed_rows[k].known);
        wait_idle();

        // Extremes of the geometry: radius zero with saturated weights passes every
        // pixel through; widths and heights of zero and beyond the maximum are clamped.
        // The very large frames are abandoned part way to keep the run short.
        run_frame(2'd0, 11'd4, 13'd2, 17'h1FFFF, 17'h1FFFF, 17'd0, 17'd0, 0);
        run_frame(2'd3, 11'd0, 13'd0, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 0);
        run_frame(2'd3, 11'd7, 13'd7, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 0);
        run_frame(2'd0, 11'h7FF, 13'd1, 17'd65536, 17'd0, 17'd0, 17'd0, 1);
        run_frame(2'd1, 11'd1024, 13'd1, 17'd30000, 17'd17000, 17'd0, 17'd0, 1);
        run_frame(2'd0, 11'd1, 13'h1FFF, 17'd65536, 17'd0, 17'd0, 17'd0, 1);
        run_frame(2'd2, 11'd9, 13'd4097, 17'd20000, 17'd15000, 17'd8000, 17'd0, 1);

        // Random frames, mostly small and whole; a few are abandoned part way.
        for (int f = 0; f < 22; f++) begin
            calm = (f >= 6 && f < 12);
            run_frame(2'($urandom_range(3)), 11'($urandom_range(1, 12)),
                      13'($urandom_range(1, 9)),
                      random_weight(), random_weight(), random_weight(), random_weight(),
                      $urandom_range(9) == 0);
        end
        calm = 0;

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
